FILE: rtl/pim_pkg.sv
// ============================================================================
// pim_pkg: shared types and constants of the pointer and key input mapper
// Holds the logical grid size, the key ring depth, the request and action
// codes, and the structs that travel between the front and back parts.
// ============================================================================
package pim_pkg;

    // Logical grid and key ring sizes.
    localparam int LOGICAL_WIDTH  = 1280;
    localparam int LOGICAL_HEIGHT = 720;
    localparam int RING_DEPTH     = 256;
    localparam int RING_AW        = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    // Field widths fixed by the interface.
    localparam int COORD_W  = 14;   // window coordinates and viewport corner
    localparam int DIM_W    = 15;   // viewport width and height
    localparam int PTR_X_W  = 11;
    localparam int PTR_Y_W  = 10;
    localparam int BYTE_W   = 8;

    // Scaling datapath widths.
    localparam int LW_BITS  = $clog2(LOGICAL_WIDTH + 1);
    localparam int LH_BITS  = $clog2(LOGICAL_HEIGHT + 1);
    localparam int SCALE_W  = (LW_BITS > LH_BITS) ? LW_BITS : LH_BITS;
    localparam int MUL_W    = COORD_W + SCALE_W;
    localparam int QX_BITS  = (LOGICAL_WIDTH > 1) ? $clog2(LOGICAL_WIDTH) : 1;
    localparam int QY_BITS  = (LOGICAL_HEIGHT > 1) ? $clog2(LOGICAL_HEIGHT) : 1;
    localparam int QUO_W    = (QX_BITS > QY_BITS) ? QX_BITS : QY_BITS;
    localparam int STEP_W   = (QUO_W > 1) ? $clog2(QUO_W) : 1;
    localparam int REM_W    = DIM_W;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Key bytes.
    localparam logic [BYTE_W-1:0] KEY_BACKSPACE = 8'h08;
    localparam logic [BYTE_W-1:0] KEY_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] KEY_RETURN    = 8'h0D;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_VIEW_LEFT   = 3'd0;
    localparam logic [2:0] REG_VIEW_TOP    = 3'd1;
    localparam logic [2:0] REG_VIEW_WIDTH  = 3'd2;
    localparam logic [2:0] REG_VIEW_HEIGHT = 3'd3;
    localparam logic [2:0] REG_FOCUS       = 3'd4;

    typedef enum logic [2:0] {
        REQ_DOWN  = 3'd0,
        REQ_UP    = 3'd1,
        REQ_MOVE  = 3'd2,
        REQ_TEXT  = 3'd3,
        REQ_BKSP  = 3'd4,
        REQ_ENTER = 3'd5,
        REQ_POP   = 3'd6
    } t_req;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_DOWN,
        OP_UP,
        OP_MOVE,
        OP_PUSH,
        OP_POP
    } t_op;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_READY  = 2'd3
    } t_act;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic {
        B_IDLE,
        B_POP
    } t_bstate;

    typedef struct packed {
        logic [COORD_W-1:0] view_left;
        logic [COORD_W-1:0] view_top;
        logic [DIM_W-1:0]   view_width;
        logic [DIM_W-1:0]   view_height;
        logic               focus_present;
    } t_cfg;

    typedef struct packed {
        logic [2:0]         req_type;
        logic               left_button;
        logic [COORD_W-1:0] win_x;
        logic [COORD_W-1:0] win_y;
        logic [BYTE_W-1:0]  text_byte;
    } t_item;

    typedef struct packed {
        t_op                op;
        logic [BYTE_W-1:0]  data;
        logic [PTR_X_W-1:0] px;
        logic [PTR_Y_W-1:0] py;
    } t_cmd;

    typedef struct packed {
        logic               in_view;
        logic [PTR_X_W-1:0] ptr_x;
        logic [PTR_Y_W-1:0] ptr_y;
        logic               pressed;
        t_act               key_action;
        logic [BYTE_W-1:0]  key_out;
    } t_res;

endpackage

FILE: rtl/pim_ram.sv
// ============================================================================
// pim_ram: generic simple dual-port RAM
// One write port and one read port with registered read data that holds
// its value while no read is issued.
// ============================================================================
module pim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pim_fifo.sv
// ============================================================================
// pim_fifo: command queue between the front and back parts
// Four flip-flop entries; push and pop may happen in the same cycle.
// ============================================================================
module pim_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pim_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pim_pkg::t_cmd o_data
);
    import pim_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push;
    logic                do_pop;

    function automatic logic [QUEUE_AW-1:0] wrap_inc(input logic [QUEUE_AW-1:0] p);
        return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= wrap_inc(r_wr);
            end
            if (do_pop) begin
                r_rd <= wrap_inc(r_rd);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/pim_front.sv
// ============================================================================
// pim_front: request classification and viewport scaling
// Accepts one item at a time, checks pointer events against the viewport,
// scales the offset with a constant multiply and a two-lane restoring
// divider (one quotient bit per cycle), and queues a command.
// ============================================================================
module pim_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pim_pkg::t_cfg                 i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  pim_pkg::t_item                i_item,
    output logic                          o_push,
    output pim_pkg::t_cmd                 o_cmd,
    input  logic                          i_full
);
    import pim_pkg::*;

    t_fstate             r_state;
    t_fstate             n_state;
    t_op                 r_op;
    logic [BYTE_W-1:0]   r_byte;
    logic [COORD_W-1:0]  r_ox;
    logic [COORD_W-1:0]  r_oy;
    logic [REM_W-1:0]    r_remx;
    logic [REM_W-1:0]    r_remy;
    logic [QUO_W-1:0]    r_lowx;
    logic [QUO_W-1:0]    r_lowy;
    logic [QUO_W-1:0]    r_qx;
    logic [QUO_W-1:0]    r_qy;
    logic [STEP_W-1:0]   r_step;

    logic                accept;
    logic                in_x;
    logic                in_y;
    logic [COORD_W-1:0]  off_x;
    logic [COORD_W-1:0]  off_y;
    t_op                 cls_op;
    logic [BYTE_W-1:0]   cls_byte;
    logic [MUL_W-1:0]    prod_x;
    logic [MUL_W-1:0]    prod_y;
    logic [REM_W:0]      try_x;
    logic [REM_W:0]      try_y;
    logic                ge_x;
    logic                ge_y;
    logic                last_step;

    // Viewport test on the incoming item.
    assign off_x = i_item.win_x - i_cfg.view_left;
    assign off_y = i_item.win_y - i_cfg.view_top;
    assign in_x  = (i_item.win_x >= i_cfg.view_left) && ({1'b0, off_x} < i_cfg.view_width);
    assign in_y  = (i_item.win_y >= i_cfg.view_top) && ({1'b0, off_y} < i_cfg.view_height);

    always_comb begin
        cls_op   = OP_NONE;
        cls_byte = '0;
        case (t_req'(i_item.req_type))
            REQ_DOWN:  cls_op = (i_item.left_button && in_x && in_y) ? OP_DOWN : OP_NONE;
            REQ_UP:    cls_op = (i_item.left_button && in_x && in_y) ? OP_UP : OP_NONE;
            REQ_MOVE:  cls_op = (in_x && in_y) ? OP_MOVE : OP_NONE;
            REQ_TEXT: begin
                // A text stream carries no zero byte, so one is dropped here.
                cls_op   = (i_item.text_byte != '0) ? OP_PUSH : OP_NONE;
                cls_byte = i_item.text_byte;
            end
            REQ_BKSP: begin
                cls_op   = OP_PUSH;
                cls_byte = KEY_BACKSPACE;
            end
            REQ_ENTER: begin
                cls_op   = OP_PUSH;
                cls_byte = KEY_NEWLINE;
            end
            REQ_POP:   cls_op = OP_POP;
            default:   cls_op = OP_NONE;
        endcase
    end

    // Scaling: offset times grid size, then restoring division by the
    // viewport size. The quotient is known to stay below 2**QUO_W.
    assign prod_x    = MUL_W'(r_ox) * MUL_W'(LOGICAL_WIDTH);
    assign prod_y    = MUL_W'(r_oy) * MUL_W'(LOGICAL_HEIGHT);
    assign try_x     = {r_remx, r_lowx[QUO_W-1]};
    assign try_y     = {r_remy, r_lowy[QUO_W-1]};
    assign ge_x      = (try_x >= {1'b0, i_cfg.view_width});
    assign ge_y      = (try_y >= {1'b0, i_cfg.view_height});
    assign last_step = (r_step == STEP_W'(QUO_W - 1));

    assign accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = (cls_op == OP_DOWN || cls_op == OP_UP || cls_op == OP_MOVE)
                              ? F_MUL : F_PUSH;
                end
            end
            F_MUL:  n_state = F_DIV;
            F_DIV:  n_state = last_step ? F_PUSH : F_DIV;
            F_PUSH: n_state = i_full ? F_PUSH : F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        case (r_state)
            F_IDLE:  o_ready = 1'b1;
            F_PUSH:  o_push  = !i_full;
            default: begin
                o_ready = 1'b0;
                o_push  = 1'b0;
            end
        endcase
    end

    assign o_cmd.op   = r_op;
    assign o_cmd.data = r_byte;
    assign o_cmd.px   = PTR_X_W'(r_qx);
    assign o_cmd.py   = PTR_Y_W'(r_qy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= cls_op;
            r_byte <= cls_byte;
            r_ox   <= off_x;
            r_oy   <= off_y;
        end
        if (r_state == F_MUL) begin
            r_remx <= REM_W'(prod_x >> QUO_W);
            r_remy <= REM_W'(prod_y >> QUO_W);
            r_lowx <= prod_x[QUO_W-1:0];
            r_lowy <= prod_y[QUO_W-1:0];
            r_step <= '0;
        end
        if (r_state == F_DIV) begin
            r_remx <= ge_x ? REM_W'(try_x - {1'b0, i_cfg.view_width}) : REM_W'(try_x);
            r_remy <= ge_y ? REM_W'(try_y - {1'b0, i_cfg.view_height}) : REM_W'(try_y);
            r_lowx <= r_lowx << 1;
            r_lowy <= r_lowy << 1;
            r_qx   <= QUO_W'({r_qx, ge_x});
            r_qy   <= QUO_W'({r_qy, ge_y});
            r_step <= r_step + 1'b1;
        end
    end

endmodule

FILE: rtl/pim_back.sv
// ============================================================================
// pim_back: state update and key ring
// Executes queued commands against the pointer state and the key ring,
// and holds each result in an output register until it is taken.
// ============================================================================
module pim_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_focus,
    input  logic          i_q_valid,
    input  pim_pkg::t_cmd i_cmd,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output pim_pkg::t_res o_res
);
    import pim_pkg::*;

    t_bstate              r_state;
    t_bstate              n_state;
    logic [RING_AW-1:0]   r_head;
    logic [RING_AW-1:0]   r_tail;
    logic [RING_AW-1:0]   n_head;
    logic [RING_AW-1:0]   n_tail;
    logic [PTR_X_W-1:0]   r_px;
    logic [PTR_Y_W-1:0]   r_py;
    logic                 r_down;
    logic [PTR_X_W-1:0]   n_px;
    logic [PTR_Y_W-1:0]   n_py;
    logic                 n_down;
    logic                 r_ovalid;
    t_res                 r_res;
    t_res                 n_res;

    logic                 can_load;
    logic                 go;
    logic                 pop_hit;
    logic                 load;
    logic                 applied;
    logic                 ram_we;
    logic                 ram_re;
    logic [BYTE_W-1:0]    ram_rdata;
    logic [RING_AW-1:0]   tail_inc;
    logic [RING_AW-1:0]   head_inc;

    function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] p);
        return (p == RING_AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign tail_inc = ring_inc(r_tail);
    assign head_inc = ring_inc(r_head);
    assign can_load = !r_ovalid || i_ready;
    assign go       = (r_state == B_IDLE) && i_q_valid && can_load;
    assign pop_hit  = go && (i_cmd.op == OP_POP) && i_focus && (r_head != r_tail);

    pim_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (i_cmd.data),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  n_state = pop_hit ? B_POP : B_IDLE;
            B_POP:   n_state = can_load ? B_IDLE : B_POP;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_px    = r_px;
        n_py    = r_py;
        n_down  = r_down;
        n_res   = r_res;
        applied = 1'b0;
        ram_we  = 1'b0;
        ram_re  = 1'b0;
        o_q_pop = 1'b0;
        load    = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (go) begin
                    o_q_pop = 1'b1;
                    case (i_cmd.op)
                        OP_DOWN, OP_UP: begin
                            n_px    = i_cmd.px;
                            n_py    = i_cmd.py;
                            n_down  = (i_cmd.op == OP_DOWN);
                            applied = 1'b1;
                        end
                        OP_MOVE: begin
                            n_px    = i_cmd.px;
                            n_py    = i_cmd.py;
                            applied = 1'b1;
                        end
                        OP_PUSH: begin
                            // A full ring gives up its oldest byte.
                            ram_we = 1'b1;
                            n_tail = tail_inc;
                            if (tail_inc == r_head) begin
                                n_head = head_inc;
                            end
                        end
                        OP_POP: begin
                            if (pop_hit) begin
                                ram_re = 1'b1;
                                n_head = head_inc;
                            end
                        end
                        default: applied = 1'b0;
                    endcase
                    load             = !pop_hit;
                    n_res.in_view    = applied;
                    n_res.ptr_x      = n_px;
                    n_res.ptr_y      = n_py;
                    n_res.pressed    = n_down;
                    n_res.key_action = ACT_NONE;
                    n_res.key_out    = '0;
                end
            end
            B_POP: begin
                if (can_load) begin
                    load          = 1'b1;
                    n_res.in_view = 1'b0;
                    n_res.ptr_x   = r_px;
                    n_res.ptr_y   = r_py;
                    n_res.pressed = r_down;
                    n_res.key_out = '0;
                    if (ram_rdata == KEY_BACKSPACE) begin
                        n_res.key_action = ACT_DELETE;
                    end else if (ram_rdata == KEY_NEWLINE || ram_rdata == KEY_RETURN) begin
                        n_res.key_action = ACT_READY;
                    end else begin
                        n_res.key_action = ACT_INSERT;
                        n_res.key_out    = ram_rdata;
                    end
                end
            end
            default: load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_down   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_px    <= n_px;
            r_py    <= n_py;
            r_down  <= n_down;
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= RING_AW'(RING_DEPTH - 1)) && (r_tail <= RING_AW'(RING_DEPTH - 1)))
        else $error("key ring pointer out of range");

    a_pop_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == B_POP) |-> $past(pop_hit))
        else $error("pop state entered without a granted pop");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_POP && can_load) |=> (r_ovalid && r_res.key_action != ACT_NONE))
        else $error("granted pop delivered no key action");

endmodule

FILE: rtl/pointer_and_key_input_mapper_unit.sv
// ============================================================================
// pointer_and_key_input_mapper_unit: pointer scaling and key ring top level
// A pointer event inside the viewport passes the multiply state, the divider
// steps, the queue push and the state update before its result is on the
// output; other items skip the multiply and divider states, and a granted pop
// adds a ring read state. The front part takes a new item only once the last
// one is pushed into the queue, and that push stalls while the queue is full.
// Reset is synchronous, active low: it clears the pointer, the pressed flag,
// the ring pointers, the queue and the configuration registers to their
// defaults; the ring memory itself is not cleared.
// ============================================================================
module pointer_and_key_input_mapper_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // left_button [0], win_x [14:1], win_y [28:15], text_byte [36:29], zero [39:37]
    input  logic [39:0] s_axis_tdata,
    // req_type [2:0]
    input  logic [2:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // in_view [0], ptr_x [11:1], ptr_y [21:12], pressed [22], key_out [30:23], zero [31]
    output logic [31:0] m_axis_tdata,
    // key_action [1:0]
    output logic [1:0]  m_axis_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pim_pkg::*;

    // Configuration registers. A width or height written as zero is kept
    // as one so that the divider never sees a zero divisor.
    t_cfg               r_cfg;
    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    logic [DIM_W-1:0]   wr_dim;

    t_item              item;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    t_cmd               q_in;
    t_cmd               q_out;
    t_res               res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];
    assign wr_dim  = (pwdata[DIM_W-1:0] == '0) ? DIM_W'(1) : pwdata[DIM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_left     <= '0;
            r_cfg.view_top      <= '0;
            r_cfg.view_width    <= DIM_W'(LOGICAL_WIDTH);
            r_cfg.view_height   <= DIM_W'(LOGICAL_HEIGHT);
            r_cfg.focus_present <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_VIEW_LEFT:   r_cfg.view_left     <= pwdata[COORD_W-1:0];
                REG_VIEW_TOP:    r_cfg.view_top      <= pwdata[COORD_W-1:0];
                REG_VIEW_WIDTH:  r_cfg.view_width    <= wr_dim;
                REG_VIEW_HEIGHT: r_cfg.view_height   <= wr_dim;
                REG_FOCUS:       r_cfg.focus_present <= pwdata[0];
                default:         r_cfg.focus_present <= r_cfg.focus_present;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_VIEW_LEFT:   prdata = 32'(r_cfg.view_left);
            REG_VIEW_TOP:    prdata = 32'(r_cfg.view_top);
            REG_VIEW_WIDTH:  prdata = 32'(r_cfg.view_width);
            REG_VIEW_HEIGHT: prdata = 32'(r_cfg.view_height);
            REG_FOCUS:       prdata = 32'(r_cfg.focus_present);
            default:         prdata = '0;
        endcase
    end

    // Unpack the input item.
    assign item.req_type    = s_axis_tuser;
    assign item.left_button = s_axis_tdata[0];
    assign item.win_x       = s_axis_tdata[14:1];
    assign item.win_y       = s_axis_tdata[28:15];
    assign item.text_byte   = s_axis_tdata[36:29];

    // Front part: classification and viewport scaling.
    pim_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (item),
        .o_push  (q_push),
        .o_cmd   (q_in),
        .i_full  (q_full)
    );

    // Short command queue so that the two parts stall independently.
    pim_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // Back part: pointer state, key ring and the result register.
    pim_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_focus   (r_cfg.focus_present),
        .i_q_valid (q_valid),
        .i_cmd     (q_out),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_res     (res)
    );

    // Pack the result item.
    assign m_axis_tdata = {1'b0, res.key_out, res.pressed, res.ptr_y, res.ptr_x, res.in_view};
    assign m_axis_tuser = res.key_action;

endmodule

FILE: verif/tb_pointer_and_key_input_mapper_unit.sv
// ============================================================================
// tb_pointer_and_key_input_mapper_unit: self-checking bench for the input mapper
// Drives pointer and key items into the stream input and writes the viewport
// registers over the APB port between phases. A scoreboard class predicts every
// result (scaled pointer, pressed flag, key ring pops) and compares it field by
// field with what the block returns, under random idling on both streams.
// ============================================================================
module tb_pointer_and_key_input_mapper_unit;

    import pim_pkg::*;

    // Request code that the block must ignore, and a register index past the
    // last register, whose writes must have no effect.
    localparam logic [2:0] REQ_UNUSED_CODE = 3'd7;
    localparam logic [2:0] REG_UNUSED      = 3'd5;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the registers and of the pointer and
    // key ring state, predicts one result per accepted item and checks the
    // results in order.
    // ------------------------------------------------------------------------
    class mapper_scoreboard;
        int unsigned       view_left;
        int unsigned       view_top;
        int unsigned       view_width;
        int unsigned       view_height;
        bit                focus;

        logic [PTR_X_W-1:0] cur_x;
        logic [PTR_Y_W-1:0] cur_y;
        bit                 btn_pressed;
        logic [BYTE_W-1:0]  key_bytes [RING_DEPTH];
        int unsigned        rd_ptr;
        int unsigned        wr_ptr;

        t_res pending_results [$];

        int errors;
        int items_seen;
        int results_seen;
        int ring_drops;
        int pops_granted;

        function new();
            view_left   = 0;
            view_top    = 0;
            view_width  = LOGICAL_WIDTH;
            view_height = LOGICAL_HEIGHT;
            focus       = 1'b0;
            cur_x       = '0;
            cur_y       = '0;
            btn_pressed = 1'b0;
            rd_ptr      = 0;
            wr_ptr      = 0;
        endfunction

        // A zero width or height is kept as one, so the scaling never divides
        // by zero. Bits above each register's width are dropped.
        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_VIEW_LEFT:   view_left = 32'(value[COORD_W-1:0]);
                REG_VIEW_TOP:    view_top  = 32'(value[COORD_W-1:0]);
                REG_VIEW_WIDTH: begin
                    view_width = 32'(value[DIM_W-1:0]);
                    if (view_width == 0) view_width = 1;
                end
                REG_VIEW_HEIGHT: begin
                    view_height = 32'(value[DIM_W-1:0]);
                    if (view_height == 0) view_height = 1;
                end
                REG_FOCUS:       focus = value[0];
                default: ;
            endcase
        endfunction

        // The ring keeps one slot free; a push into a full ring drops the
        // oldest byte first.
        function void push_key(logic [BYTE_W-1:0] b);
            int unsigned nxt;
            nxt = (wr_ptr + 1) % RING_DEPTH;
            if (nxt == rd_ptr) begin
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                ring_drops++;
            end
            key_bytes[wr_ptr[RING_AW-1:0]] = b;
            wr_ptr = nxt;
        endfunction

        // Scales a window point into the logical grid and stores it, when the
        // point lies in the viewport.
        function bit place_pointer(int unsigned wx, int unsigned wy);
            longint unsigned sx;
            longint unsigned sy;
            if (wx < view_left || wy < view_top) return 1'b0;
            if (wx >= view_left + view_width || wy >= view_top + view_height) return 1'b0;
            sx = longint'(wx - view_left) * LOGICAL_WIDTH / view_width;
            sy = longint'(wy - view_top) * LOGICAL_HEIGHT / view_height;
            cur_x = sx[PTR_X_W-1:0];
            cur_y = sy[PTR_Y_W-1:0];
            return 1'b1;
        endfunction

        function void note_item(t_item it);
            t_res              r;
            logic [BYTE_W-1:0] b;
            r = '0;
            case (it.req_type)
                REQ_DOWN, REQ_UP: begin
                    if (it.left_button && place_pointer(32'(it.win_x), 32'(it.win_y))) begin
                        btn_pressed = (it.req_type == REQ_DOWN);
                        r.in_view   = 1'b1;
                    end
                end
                REQ_MOVE:  r.in_view = place_pointer(32'(it.win_x), 32'(it.win_y));
                REQ_TEXT:  if (it.text_byte != 0) push_key(it.text_byte);
                REQ_BKSP:  push_key(KEY_BACKSPACE);
                REQ_ENTER: push_key(KEY_NEWLINE);
                REQ_POP: begin
                    if (focus && rd_ptr != wr_ptr) begin
                        b = key_bytes[rd_ptr[RING_AW-1:0]];
                        rd_ptr = (rd_ptr + 1) % RING_DEPTH;
                        pops_granted++;
                        if (b == KEY_BACKSPACE) begin
                            r.key_action = ACT_DELETE;
                        end else if (b == KEY_NEWLINE || b == KEY_RETURN) begin
                            r.key_action = ACT_READY;
                        end else begin
                            r.key_action = ACT_INSERT;
                            r.key_out    = b;
                        end
                    end
                end
                default: ;
            endcase
            r.ptr_x   = cur_x;
            r.ptr_y   = cur_y;
            r.pressed = btn_pressed;
            pending_results.push_back(r);
            items_seen++;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_result(t_res got);
            t_res want;
            results_seen++;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                return;
            end
            want = pending_results.pop_front();
            if (got.in_view !== want.in_view)
                report($sformatf("result %0d in_view %0b, expected %0b",
                                 results_seen, got.in_view, want.in_view));
            if (got.ptr_x !== want.ptr_x)
                report($sformatf("result %0d ptr_x %0d, expected %0d",
                                 results_seen, got.ptr_x, want.ptr_x));
            if (got.ptr_y !== want.ptr_y)
                report($sformatf("result %0d ptr_y %0d, expected %0d",
                                 results_seen, got.ptr_y, want.ptr_y));
            if (got.pressed !== want.pressed)
                report($sformatf("result %0d pressed %0b, expected %0b",
                                 results_seen, got.pressed, want.pressed));
            if (got.key_action !== want.key_action)
                report($sformatf("result %0d key_action %0d, expected %0d",
                                 results_seen, got.key_action, want.key_action));
            if (got.key_out !== want.key_out)
                report($sformatf("result %0d key_out %h, expected %h",
                                 results_seen, got.key_out, want.key_out));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test.
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // left_button, win_x, win_y, text_byte, zero pad
    logic [2:0]  s_axis_tuser;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // in_view, ptr_x, ptr_y, pressed, key_out, zero pad
    logic [1:0]  m_axis_tuser;   // key_action
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pointer_and_key_input_mapper_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mapper_scoreboard book;

    // When set, both streams draw a random wait before each item; some phases
    // clear it so the block also sees back-to-back traffic.
    bit idle_on;
    int settings_count;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // The run is cut off here if the block hangs.
    initial begin
        #(12 * 1000000);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driving tasks.
    // ------------------------------------------------------------------------
    function automatic t_item make_item(logic [2:0] req, logic left, int unsigned x,
                                        int unsigned y, logic [BYTE_W-1:0] b);
        t_item it;
        it.req_type    = req;
        it.left_button = left;
        it.win_x       = x[COORD_W-1:0];
        it.win_y       = y[COORD_W-1:0];
        it.text_byte   = b;
        return it;
    endfunction

    // Draws one item. Pointer events aim mostly inside the current viewport,
    // with some right on its edges and some anywhere in the window. Key items
    // favor ordinary text bytes but also carry the control bytes and zero.
    function automatic t_item random_item(int unsigned pct_ptr, int unsigned pct_push);
        t_item       it;
        int unsigned roll;
        int unsigned pos;
        it.req_type    = REQ_UNUSED_CODE;
        it.left_button = ($urandom_range(0, 7) != 0);
        it.win_x       = COORD_W'($urandom);
        it.win_y       = COORD_W'($urandom);
        it.text_byte   = BYTE_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < pct_ptr) begin
            it.req_type = 3'($urandom_range(int'(REQ_DOWN), int'(REQ_MOVE)));
            case ($urandom_range(0, 7))
                0: ;
                1: begin
                    // Just past the right or bottom edge, or on the corner.
                    pos = book.view_left + book.view_width - $urandom_range(0, 1);
                    it.win_x = (pos > 16383) ? 14'h3FFF : pos[COORD_W-1:0];
                    pos = book.view_top + book.view_height - $urandom_range(0, 1);
                    it.win_y = (pos > 16383) ? 14'h3FFF : pos[COORD_W-1:0];
                end
                2: begin
                    it.win_x = COORD_W'(book.view_left - $urandom_range(0, 1));
                    it.win_y = COORD_W'(book.view_top);
                end
                default: begin
                    pos = book.view_left + $urandom_range(0, book.view_width - 1);
                    it.win_x = (pos > 16383) ? 14'h3FFF : pos[COORD_W-1:0];
                    pos = book.view_top + $urandom_range(0, book.view_height - 1);
                    it.win_y = (pos > 16383) ? 14'h3FFF : pos[COORD_W-1:0];
                end
            endcase
        end else if (roll < pct_ptr + pct_push) begin
            case ($urandom_range(0, 9))
                0: it.req_type = REQ_BKSP;
                1: it.req_type = REQ_ENTER;
                2: begin
                    it.req_type = REQ_TEXT;
                    case ($urandom_range(0, 3))
                        0: it.text_byte = 8'h00;
                        1: it.text_byte = KEY_RETURN;
                        2: it.text_byte = KEY_BACKSPACE;
                        default: it.text_byte = KEY_NEWLINE;
                    endcase
                end
                default: it.req_type = REQ_TEXT;
            endcase
        end else if (roll < 98) begin
            it.req_type = REQ_POP;
        end
        return it;
    endfunction

    // Offers one item after a random gap and waits for it to be taken.
    task automatic send_item(input t_item it);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.req_type;
        s_axis_tdata  <= {3'b000, it.text_byte, it.win_y, it.win_x, it.left_button};
        do @(posedge i_clk); while (!s_axis_tready);
        book.note_item(it);
    endtask

    // Stops offering items and waits until every expected result is back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (book.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book.write_reg(idx, value);
    endtask

    // Rewrites all five registers once the block is idle. With junk set, the
    // bits above each register's width carry random values that must be lost.
    task automatic set_view(input int unsigned left, input int unsigned top,
                            input int unsigned width, input int unsigned height,
                            input bit foc, input bit junk);
        logic [31:0] noise;
        drain();
        noise = junk ? $urandom : 32'h0;
        apb_write(REG_VIEW_LEFT,   left   | (noise & 32'hFFFF_C000));
        apb_write(REG_VIEW_TOP,    top    | (noise & 32'hFFFF_C000));
        apb_write(REG_VIEW_WIDTH,  width  | (noise & 32'hFFFF_8000));
        apb_write(REG_VIEW_HEIGHT, height | (noise & 32'hFFFF_8000));
        apb_write(REG_FOCUS,       foc    | (noise & 32'hFFFF_FFFE));
        settings_count++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: takes results after a random stall and checks each one.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned stall;
        t_res        got;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = idle_on ? $urandom_range(0, 8) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.in_view    = m_axis_tdata[0];
            got.ptr_x      = m_axis_tdata[11:1];
            got.ptr_y      = m_axis_tdata[21:12];
            got.pressed    = m_axis_tdata[22];
            got.key_out    = m_axis_tdata[30:23];
            got.key_action = t_act'(m_axis_tuser);
            book.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned left;
        int unsigned top;
        int unsigned width;
        int unsigned height;

        book           = new();
        settings_count = 1;
        idle_on        = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;

        i_rst_n <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part under the reset viewport, which maps window pixels
        // one to one: grid corners, points just outside, the pressed flag
        // with left and other buttons, and a pop while nothing has focus.
        send_item(make_item(REQ_MOVE, 1'b0, 0, 0, 8'h00));
        send_item(make_item(REQ_MOVE, 1'b1, 1279, 719, 8'hFF));
        send_item(make_item(REQ_MOVE, 1'b1, 1280, 100, 8'h00));
        send_item(make_item(REQ_MOVE, 1'b1, 100, 720, 8'h00));
        send_item(make_item(REQ_DOWN, 1'b1, 640, 360, 8'h00));
        send_item(make_item(REQ_DOWN, 1'b0, 100, 100, 8'h00));
        send_item(make_item(REQ_UP,   1'b1, 16383, 16383, 8'h00));
        send_item(make_item(REQ_UP,   1'b1, 10, 10, 8'h00));
        // A zero text byte must not reach the ring; the others fill it with a
        // byte of every pop class.
        send_item(make_item(REQ_TEXT,  1'b1, 0, 0, 8'h00));
        send_item(make_item(REQ_TEXT,  1'b0, 0, 0, 8'hFF));
        send_item(make_item(REQ_TEXT,  1'b0, 0, 0, 8'h41));
        send_item(make_item(REQ_TEXT,  1'b0, 0, 0, KEY_RETURN));
        send_item(make_item(REQ_TEXT,  1'b0, 0, 0, 8'h01));
        send_item(make_item(REQ_BKSP,  1'b0, 0, 0, 8'h00));
        send_item(make_item(REQ_ENTER, 1'b0, 0, 0, 8'h00));
        send_item(make_item(REQ_POP,   1'b0, 0, 0, 8'h00));
        send_item(make_item(REQ_UNUSED_CODE, 1'b1, 16383, 16383, 8'hFF));

        // A write past the last register must change nothing; then focus is
        // given and the ring is emptied, one pop more than it holds.
        drain();
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        apb_write(REG_FOCUS, 32'h1);
        repeat (7) send_item(make_item(REQ_POP, 1'b0, 0, 0, 8'h00));

        // Ring overflow: more pushes than slots while pops are refused,
        // then a long stretch of mostly pops once focus is back.
        idle_on = 1'b1;
        set_view(0, 0, LOGICAL_WIDTH, LOGICAL_HEIGHT, 1'b0, 1'b0);
        repeat (300) send_item(random_item(5, 95));
        set_view(0, 0, LOGICAL_WIDTH, LOGICAL_HEIGHT, 1'b1, 1'b1);
        repeat (300) send_item(random_item(5, 10));

        // Random phases, each under its own viewport. The first five pin the
        // extremes: the far window corner, zero sizes, the largest viewport, a plain
        // offset one, and a tiny one that stretches each pixel over many grid points.
        for (int p = 0; p < 10; p++) begin
            case (p)
                0: set_view(16383, 16383, 16384, 16384, 1'b1, 1'b0);
                1: set_view(0, 0, 0, 0, 1'b0, 1'b0);
                2: set_view(0, 0, 16384, 16384, 1'b1, 1'b1);
                3: set_view(100, 50, LOGICAL_WIDTH, LOGICAL_HEIGHT, 1'b1, 1'b0);
                4: set_view(3000, 40, 7, 3, 1'b1, 1'b1);
                default: begin
                    left   = $urandom_range(0, 1) ? $urandom_range(0, 2000)
                                                  : $urandom_range(0, 16383);
                    top    = $urandom_range(0, 1) ? $urandom_range(0, 2000)
                                                  : $urandom_range(0, 16383);
                    width  = $urandom_range(0, 1) ? $urandom_range(1, 2000)
                                                  : $urandom_range(1, 16384);
                    height = $urandom_range(0, 1) ? $urandom_range(1, 2000)
                                                  : $urandom_range(1, 16384);
                    set_view(left, top, width, height, 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)));
                end
            endcase
            idle_on = (p % 3 != 2);
            repeat (140) send_item(random_item(35, 35));
        end

        // Wait for the last results, then a little longer so that a stray
        // extra result would still be caught.
        drain();
        repeat (40) @(posedge i_clk);

        if (book.pending_results.size() != 0)
            book.report($sformatf("%0d results never arrived", book.pending_results.size()));
        $display("Covered %0d items under %0d register settings, %0d results checked.",
                 book.items_seen, settings_count, book.results_seen);
        $display("Key ring saw %0d granted pops and %0d bytes dropped when full; %0d mismatches.",
                 book.pops_granted, book.ring_drops, book.errors);
        if (book.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/pim_pkg.sv
rtl/pim_ram.sv
rtl/pim_fifo.sv
rtl/pim_front.sv
rtl/pim_back.sv
rtl/pointer_and_key_input_mapper_unit.sv
verif/tb_pointer_and_key_input_mapper_unit.sv
